// ===== rtl/ast_pkg.sv =====
// Shared constants, field widths and codes for the atom slot and bond table store.
`timescale 1ns / 1ps
`default_nettype none
package ast_pkg;
  localparam int ATOM_SLOTS_DEF = 1024;
  localparam int BOND_SLOTS_DEF = 2048;

  localparam int KIND_W  = 3;
  localparam int ATOM_W  = 10;
  localparam int ORDER_W = 8;
  localparam int TYPE_W  = 8;
  localparam int BSLOT_W = 11;
  localparam int RANK_W  = 11;
  localparam int STAT_W  = 2;
  localparam int ID_W    = 32;
  localparam int COUNT_W = 12;

  localparam logic [KIND_W-1:0] K_ALLOC   = 3'd0;
  localparam logic [KIND_W-1:0] K_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] K_ADD     = 3'd2;
  localparam logic [KIND_W-1:0] K_REMOVE  = 3'd3;
  localparam logic [KIND_W-1:0] K_BETWEEN = 3'd4;
  localparam logic [KIND_W-1:0] K_QUERY   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOP   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/ast_if.sv =====
// Valid/ready channel interfaces for operation items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface ast_in_if import ast_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ATOM_W-1:0]  atom_a;
  logic [ATOM_W-1:0]  atom_b;
  logic [ORDER_W-1:0] bond_order;
  logic [TYPE_W-1:0]  bond_kind_code;
  logic [BSLOT_W-1:0] bond_slot_in;
  logic [RANK_W-1:0]  rank;
  modport source (output valid, kind, atom_a, atom_b, bond_order, bond_kind_code,
                  bond_slot_in, rank, input ready);
  modport sink (input valid, kind, atom_a, atom_b, bond_order, bond_kind_code,
                bond_slot_in, rank, output ready);
endinterface

interface ast_out_if import ast_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ATOM_W-1:0]  atom_slot;
  logic [ID_W-1:0]    stable_id;
  logic [BSLOT_W-1:0] bond_slot;
  logic [COUNT_W-1:0] removed_count;
  logic [COUNT_W-1:0] degree;
  logic [BSLOT_W-1:0] neighbour_bond;
  logic               neighbour_valid;
  modport source (output valid, status, atom_slot, stable_id, bond_slot, removed_count,
                  degree, neighbour_bond, neighbour_valid, input ready);
  modport sink (input valid, status, atom_slot, stable_id, bond_slot, removed_count,
                degree, neighbour_bond, neighbour_valid, output ready);
endinterface
`default_nettype wire

// ===== rtl/ast_ram.sv =====
// Single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ast_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ast_flag_ram.sv =====
// Freed-flag RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module ast_flag_ram #(
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic                     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic                          rdata0,
  output logic                          rdata1
);
  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end
endmodule
`default_nettype wire

// ===== rtl/atom_slot_and_bond_table_store.sv =====
// Top level: atom slot pool and bond table store with table-scan sequencer.
// Usage: operation items enter on in_ch (valid/ready), one result item per
// operation leaves on out_ch (valid/ready). One operation is worked at a time.
// Allocate, release, add bond and remove bond pass, after accept, through a
// memory read state, an execute state, then the output register.
// The next item is accepted once the result is loaded into the output register.
// Remove-between and neighbour query sweep the bond table through the record
// RAM read port, one slot per cycle, from slot 0 up to bond_high_water, and
// then present their result through the output register.
// Atom freed flags, atom free stack, bond records and bond free stack live in
// synchronous RAMs; the high-water marks and stack counts bound every read,
// so no clearing pass runs after reset.
// Reset (rst_n low, synchronous) empties both pools and zeroes the id counter;
// the block accepts an item in the first cycle after reset.
// When the receiver stalls, the result waits in the output register while the
// next item is accepted and worked; the following result then waits until the
// output register frees.
`timescale 1ns / 1ps
`default_nettype none
module atom_slot_and_bond_table_store import ast_pkg::*; #(
  parameter int ATOM_SLOTS = ATOM_SLOTS_DEF,
  parameter int BOND_SLOTS = BOND_SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ast_in_if.sink   in_ch,
  ast_out_if.source out_ch
);
  localparam int AW  = $clog2(ATOM_SLOTS);
  localparam int BW  = $clog2(BOND_SLOTS);
  localparam int ACW = AW + 1;
  localparam int BCW = BW + 1;
  localparam int RW  = 2 * AW + ORDER_W + TYPE_W + 1;
  localparam int AXW = (ACW > ATOM_W) ? ACW : ATOM_W;
  localparam int BXW = (BCW > BSLOT_W) ? BCW : BSLOT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [ATOM_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [ORDER_W-1:0] ord_r, ord_nxt;
  logic [TYPE_W-1:0]  typ_r, typ_nxt;
  logic [BSLOT_W-1:0] bslot_r, bslot_nxt;
  logic [RANK_W-1:0]  rank_r, rank_nxt;

  logic [ACW-1:0] atom_hw_r, atom_hw_nxt, atom_cnt_r, atom_cnt_nxt;
  logic [BCW-1:0] bond_hw_r, bond_hw_nxt, bond_cnt_r, bond_cnt_nxt;
  logic [ID_W-1:0] next_id_r, next_id_nxt;

  logic [BCW-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic           s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic [BW-1:0]  s1_k_r, s1_k_nxt, s2_k_r, s2_k_nxt, hit_r, hit_nxt;
  logic           s2_dead_r, s2_dead_nxt, found_r, found_nxt;
  logic [AW-1:0]  s2_a_r, s2_a_nxt, s2_b_r, s2_b_nxt;

  logic [STAT_W-1:0]  pst_r, pst_nxt, ost_r, ost_nxt;
  logic [ATOM_W-1:0]  pslot_r, pslot_nxt, oslot_r, oslot_nxt;
  logic [ID_W-1:0]    pid_r, pid_nxt, oid_r, oid_nxt;
  logic [BSLOT_W-1:0] pbond_r, pbond_nxt, obond_r, obond_nxt;
  logic [COUNT_W-1:0] prem_r, prem_nxt, orem_r, orem_nxt;
  logic [COUNT_W-1:0] pdeg_r, pdeg_nxt, odeg_r, odeg_nxt;
  logic [BSLOT_W-1:0] pnb_r, pnb_nxt, onb_r, onb_nxt;
  logic               pnv_r, pnv_nxt, onv_r, onv_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic          astk_we;
  logic [AW-1:0] astk_wa, astk_wd, astk_ra, astk_rd;
  logic          flag_we, flag_wd, flag_rd0, flag_rd1;
  logic [AW-1:0] flag_wa, flag_ra0, flag_ra1;
  logic          bstk_we;
  logic [BW-1:0] bstk_wa, bstk_wd, bstk_ra, bstk_rd;
  logic          rec_we;
  logic [BW-1:0] rec_wa, rec_ra;
  logic [RW-1:0] rec_wd, rec_rd;

  logic [AW-1:0] rec_a, rec_b, aidx;
  logic [BW-1:0] bidx;
  logic          rec_dead, a_bad, b_bad, bs_bad;

  assign rec_a    = rec_rd[AW-1:0];
  assign rec_b    = rec_rd[2*AW-1:AW];
  assign rec_dead = rec_rd[RW-1];
  assign a_bad    = AXW'(a_r) >= AXW'(atom_hw_r);
  assign b_bad    = AXW'(b_r) >= AXW'(atom_hw_r);
  assign bs_bad   = BXW'(bslot_r) >= BXW'(bond_hw_r);

  assign astk_ra  = AW'(atom_cnt_r - ACW'(1));
  assign bstk_ra  = BW'(bond_cnt_r - BCW'(1));
  assign flag_ra0 = (state_r == S_SCAN) ? rec_a : AW'(a_r);
  assign flag_ra1 = rec_b;
  assign rec_ra   = (state_r == S_SCAN) ? BW'(k_r) : BW'(bslot_r);

  ast_ram #(.DEPTH(ATOM_SLOTS), .WIDTH(AW)) u_atom_stack (
    .clk, .we(astk_we), .waddr(astk_wa), .wdata(astk_wd), .raddr(astk_ra), .rdata(astk_rd)
  );
  ast_flag_ram #(.DEPTH(ATOM_SLOTS)) u_atom_flags (
    .clk, .we(flag_we), .waddr(flag_wa), .wdata(flag_wd),
    .raddr0(flag_ra0), .raddr1(flag_ra1), .rdata0(flag_rd0), .rdata1(flag_rd1)
  );
  ast_ram #(.DEPTH(BOND_SLOTS), .WIDTH(BW)) u_bond_stack (
    .clk, .we(bstk_we), .waddr(bstk_wa), .wdata(bstk_wd), .raddr(bstk_ra), .rdata(bstk_rd)
  );
  ast_ram #(.DEPTH(BOND_SLOTS), .WIDTH(RW)) u_bond_records (
    .clk, .we(rec_we), .waddr(rec_wa), .wdata(rec_wd), .raddr(rec_ra), .rdata(rec_rd)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r; a_nxt = a_r; b_nxt = b_r; ord_nxt = ord_r; typ_nxt = typ_r;
    bslot_nxt = bslot_r; rank_nxt = rank_r;
    atom_hw_nxt = atom_hw_r; atom_cnt_nxt = atom_cnt_r;
    bond_hw_nxt = bond_hw_r; bond_cnt_nxt = bond_cnt_r; next_id_nxt = next_id_r;
    k_nxt = k_r; cnt_nxt = cnt_r; s1_v_nxt = 1'b0; s2_v_nxt = 1'b0;
    s1_k_nxt = BW'(k_r); s2_k_nxt = s1_k_r; s2_dead_nxt = rec_dead;
    s2_a_nxt = rec_a; s2_b_nxt = rec_b; hit_nxt = hit_r; found_nxt = found_r;
    pst_nxt = pst_r; pslot_nxt = pslot_r; pid_nxt = pid_r; pbond_nxt = pbond_r;
    prem_nxt = prem_r; pdeg_nxt = pdeg_r; pnb_nxt = pnb_r; pnv_nxt = pnv_r;
    ost_nxt = ost_r; oslot_nxt = oslot_r; oid_nxt = oid_r; obond_nxt = obond_r;
    orem_nxt = orem_r; odeg_nxt = odeg_r; onb_nxt = onb_r; onv_nxt = onv_r;
    out_valid_nxt = out_valid_r;
    astk_we = 1'b0; astk_wa = AW'(atom_cnt_r); astk_wd = AW'(a_r);
    flag_we = 1'b0; flag_wa = AW'(a_r); flag_wd = 1'b0;
    bstk_we = 1'b0; bstk_wa = BW'(bond_cnt_r); bstk_wd = BW'(bslot_r);
    rec_we = 1'b0; rec_wa = BW'(bslot_r); rec_wd = {1'b1, rec_rd[RW-2:0]};
    aidx = AW'(atom_hw_r);
    bidx = BW'(bond_hw_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = in_ch.kind; a_nxt = in_ch.atom_a; b_nxt = in_ch.atom_b;
          ord_nxt = in_ch.bond_order; typ_nxt = in_ch.bond_kind_code;
          bslot_nxt = in_ch.bond_slot_in; rank_nxt = in_ch.rank;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        pst_nxt = ST_OK; pslot_nxt = '0; pid_nxt = '0; pbond_nxt = '0;
        prem_nxt = '0; pdeg_nxt = '0; pnb_nxt = '0; pnv_nxt = 1'b0;
        state_nxt = S_DONE;
        unique case (kind_r)
          K_ALLOC: begin
            if (atom_cnt_r != '0) begin
              aidx = astk_rd;
              atom_cnt_nxt = atom_cnt_r - ACW'(1);
            end else if (atom_hw_r < ACW'(ATOM_SLOTS)) begin
              atom_hw_nxt = atom_hw_r + ACW'(1);
            end else begin
              pst_nxt = ST_FULL;
            end
            if (pst_nxt == ST_OK) begin
              flag_we = 1'b1; flag_wa = aidx; flag_wd = 1'b0;
              pslot_nxt = ATOM_W'(aidx);
              pid_nxt = next_id_r;
              next_id_nxt = next_id_r + ID_W'(1);
            end
          end
          K_RELEASE: begin
            if (a_bad) begin
              pst_nxt = ST_RANGE;
            end else if (flag_rd0) begin
              pst_nxt = ST_NOP;
            end else begin
              flag_we = 1'b1; flag_wd = 1'b1;
              if (atom_cnt_r < ACW'(ATOM_SLOTS)) begin
                astk_we = 1'b1;
                atom_cnt_nxt = atom_cnt_r + ACW'(1);
              end
            end
          end
          K_ADD: begin
            if (a_bad || b_bad) begin
              pst_nxt = ST_RANGE;
            end else begin
              if (bond_cnt_r != '0) begin
                bidx = bstk_rd;
                bond_cnt_nxt = bond_cnt_r - BCW'(1);
              end else if (bond_hw_r < BCW'(BOND_SLOTS)) begin
                bond_hw_nxt = bond_hw_r + BCW'(1);
              end else begin
                pst_nxt = ST_FULL;
              end
              if (pst_nxt == ST_OK) begin
                rec_we = 1'b1; rec_wa = bidx;
                rec_wd = {1'b0, typ_r, ord_r, AW'(b_r), AW'(a_r)};
                pbond_nxt = BSLOT_W'(bidx);
              end
            end
          end
          K_REMOVE: begin
            if (bs_bad) begin
              pst_nxt = ST_RANGE;
            end else if (rec_dead) begin
              pst_nxt = ST_NOP;
            end else begin
              rec_we = 1'b1;
              if (bond_cnt_r < BCW'(BOND_SLOTS)) begin
                bstk_we = 1'b1;
                bond_cnt_nxt = bond_cnt_r + BCW'(1);
              end
            end
          end
          K_BETWEEN, K_QUERY: begin
            if (a_bad || (kind_r == K_BETWEEN && b_bad)) begin
              pst_nxt = ST_RANGE;
            end else begin
              state_nxt = S_SCAN;
              k_nxt = '0; cnt_nxt = '0; hit_nxt = '0; found_nxt = 1'b0;
            end
          end
          default: begin
            pst_nxt = ST_NOP;
          end
        endcase
      end
      S_SCAN: begin
        if (k_r < bond_hw_r) begin
          k_nxt = k_r + BCW'(1);
          s1_v_nxt = 1'b1;
        end
        if (s1_v_r && kind_r == K_BETWEEN) begin
          if (!rec_dead && ((rec_a == AW'(a_r) && rec_b == AW'(b_r)) ||
                            (rec_a == AW'(b_r) && rec_b == AW'(a_r)))) begin
            rec_we = 1'b1; rec_wa = s1_k_r;
            cnt_nxt = cnt_r + BCW'(1);
            if (bond_cnt_r < BCW'(BOND_SLOTS)) begin
              bstk_we = 1'b1; bstk_wd = s1_k_r;
              bond_cnt_nxt = bond_cnt_r + BCW'(1);
            end
          end
        end
        s2_v_nxt = s1_v_r && (kind_r == K_QUERY);
        if (s2_v_r && !s2_dead_r && !flag_rd0 && !flag_rd1 &&
            (s2_a_r == AW'(a_r) || s2_b_r == AW'(a_r))) begin
          if (BXW'(cnt_r) == BXW'(rank_r)) begin
            hit_nxt = s2_k_r;
            found_nxt = 1'b1;
          end
          cnt_nxt = cnt_r + BCW'(1);
        end
        if (k_r == bond_hw_r && !s1_v_r && !s2_v_r) begin
          state_nxt = S_DONE;
          if (kind_r == K_BETWEEN) begin
            prem_nxt = COUNT_W'(cnt_r);
          end else begin
            pdeg_nxt = COUNT_W'(cnt_r);
            pnb_nxt = found_r ? BSLOT_W'(hit_r) : '0;
            pnv_nxt = found_r;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          ost_nxt = pst_r; oslot_nxt = pslot_r; oid_nxt = pid_r; obond_nxt = pbond_r;
          orem_nxt = prem_r; odeg_nxt = pdeg_r; onb_nxt = pnb_r; onv_nxt = pnv_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      atom_hw_r <= '0; atom_cnt_r <= '0; next_id_r <= '0;
      bond_hw_r <= '0; bond_cnt_r <= '0;
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      atom_hw_r <= atom_hw_nxt; atom_cnt_r <= atom_cnt_nxt; next_id_r <= next_id_nxt;
      bond_hw_r <= bond_hw_nxt; bond_cnt_r <= bond_cnt_nxt;
      s1_v_r <= s1_v_nxt; s2_v_r <= s2_v_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; a_r <= a_nxt; b_r <= b_nxt; ord_r <= ord_nxt; typ_r <= typ_nxt;
    bslot_r <= bslot_nxt; rank_r <= rank_nxt;
    k_r <= k_nxt; cnt_r <= cnt_nxt; s1_k_r <= s1_k_nxt; s2_k_r <= s2_k_nxt;
    s2_dead_r <= s2_dead_nxt; s2_a_r <= s2_a_nxt; s2_b_r <= s2_b_nxt;
    hit_r <= hit_nxt; found_r <= found_nxt;
    pst_r <= pst_nxt; pslot_r <= pslot_nxt; pid_r <= pid_nxt; pbond_r <= pbond_nxt;
    prem_r <= prem_nxt; pdeg_r <= pdeg_nxt; pnb_r <= pnb_nxt; pnv_r <= pnv_nxt;
    ost_r <= ost_nxt; oslot_r <= oslot_nxt; oid_r <= oid_nxt; obond_r <= obond_nxt;
    orem_r <= orem_nxt; odeg_r <= odeg_nxt; onb_r <= onb_nxt; onv_r <= onv_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = ost_r;
  assign out_ch.atom_slot       = oslot_r;
  assign out_ch.stable_id       = oid_r;
  assign out_ch.bond_slot       = obond_r;
  assign out_ch.removed_count   = orem_r;
  assign out_ch.degree          = odeg_r;
  assign out_ch.neighbour_bond  = onb_r;
  assign out_ch.neighbour_valid = onv_r;

  a_atom_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    atom_cnt_r <= atom_hw_r) else $error("atom free stack deeper than high-water mark");
  a_bond_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bond_cnt_r <= bond_hw_r) else $error("bond free stack deeper than high-water mark");
  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_ISSUE) else $error("accept did not issue");
  a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> state_r == S_SCAN) else $error("scan stage active outside scan");
endmodule
`default_nettype wire
